// File: hdl/trbr_pkg.sv
// Shared constants and codes for the triangle bounding-box rasterizer.
package trbr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_ADDR_BITS  = 3;

  // Input item function code
  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_STEP = 1'b1
  } func_t;

  // Register word index (paddr[2])
  typedef enum logic {
    REG_FILL_COLOR = 1'b0
  } reg_idx_t;

endpackage

// File: hdl/trbr_front.sv
// Front end: accepts load/step transactions, holds the box and walks the scan.
module trbr_front import trbr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic signed [COORD_BITS-1:0]      in_vert1_x,
  input  logic signed [COORD_BITS-1:0]      in_vert1_y,
  input  logic signed [COORD_BITS-1:0]      in_vert2_x,
  input  logic signed [COORD_BITS-1:0]      in_vert2_y,
  input  logic signed [COORD_BITS-1:0]      in_vert3_x,
  input  logic signed [COORD_BITS-1:0]      in_vert3_y,
  input  logic                              q_full,
  output logic                              cand_push,
  output logic [COORD_BITS-1:0]             cand_px,
  output logic [COORD_BITS-1:0]             cand_py,
  output logic                              cand_last,
  output logic [5:0][COORD_BITS-1:0]        cand_vert
);

  logic                             busy_r, busy_nxt;
  logic [5:0][COORD_BITS-1:0]       vert_r, vert_nxt;
  logic signed [COORD_BITS-1:0]     scan_x_r, scan_x_nxt;
  logic signed [COORD_BITS-1:0]     scan_y_r, scan_y_nxt;
  logic signed [COORD_BITS-1:0]     min_y_r, min_y_nxt;
  logic signed [COORD_BITS-1:0]     max_x_r, max_x_nxt;
  logic signed [COORD_BITS-1:0]     max_y_r, max_y_nxt;
  logic                             accept;
  logic                             load;
  logic                             step;
  logic                             fin;

  function automatic logic signed [COORD_BITS-1:0] min3(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b,
    input logic signed [COORD_BITS-1:0] c
  );
    logic signed [COORD_BITS-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] max3(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b,
    input logic signed [COORD_BITS-1:0] c
  );
    logic signed [COORD_BITS-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Classify the incoming transaction
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign load     = accept && (in_func == FUNC_LOAD);
  assign step     = accept && (in_func == FUNC_STEP) && busy_r;
  assign fin      = (scan_x_r >= max_x_r) && (scan_y_r >= max_y_r);

  // Hand the current candidate to the queue
  assign cand_push = step;
  assign cand_px   = scan_x_r;
  assign cand_py   = scan_y_r;
  assign cand_last = fin;
  assign cand_vert = vert_r;

  // Load a new box or advance the scan
  always_comb begin
    busy_nxt   = busy_r;
    vert_nxt   = vert_r;
    scan_x_nxt = scan_x_r;
    scan_y_nxt = scan_y_r;
    min_y_nxt  = min_y_r;
    max_x_nxt  = max_x_r;
    max_y_nxt  = max_y_r;
    if (load) begin
      vert_nxt   = {in_vert3_y, in_vert3_x, in_vert2_y, in_vert2_x, in_vert1_y, in_vert1_x};
      scan_x_nxt = min3(in_vert1_x, in_vert2_x, in_vert3_x);
      max_x_nxt  = max3(in_vert1_x, in_vert2_x, in_vert3_x);
      min_y_nxt  = min3(in_vert1_y, in_vert2_y, in_vert3_y);
      max_y_nxt  = max3(in_vert1_y, in_vert2_y, in_vert3_y);
      scan_y_nxt = min3(in_vert1_y, in_vert2_y, in_vert3_y);
      busy_nxt   = 1'b1;
    end else if (step) begin
      if (fin) begin
        busy_nxt = 1'b0;
      end else if (scan_y_r < max_y_r) begin
        scan_y_nxt = scan_y_r + COORD_BITS'(1);
      end else begin
        scan_y_nxt = min_y_r;
        scan_x_nxt = scan_x_r + COORD_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vert_r   <= vert_nxt;
    scan_x_r <= scan_x_nxt;
    scan_y_r <= scan_y_nxt;
    min_y_r  <= min_y_nxt;
    max_x_r  <= max_x_nxt;
    max_y_r  <= max_y_nxt;
  end

endmodule

// File: hdl/trbr_queue.sv
// Small FIFO that decouples the scan front end from the coverage pipeline.
module trbr_queue import trbr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;

  assign full     = (count_r == (AW+1)'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rdata    = mem_r[rd_ptr_r];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> rd_valid)
    else $error("queue read while empty");
  a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + (AW+1)'(1)))
    else $error("queue level lost a transaction");
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (AW+1)'(DEPTH))
    else $error("queue level beyond depth");
`endif

endmodule

// File: hdl/trbr_back.sv
// Back end: edge-function products, coverage decision and output register.
module trbr_back import trbr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  logic [COORD_BITS-1:0]             cand_px,
  input  logic [COORD_BITS-1:0]             cand_py,
  input  logic                              cand_last,
  input  logic [5:0][COORD_BITS-1:0]        cand_vert,
  input  logic [COLOR_BITS-1:0]             fill_color,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_BITS-1:0]      out_pixel_x,
  output logic signed [COORD_BITS-1:0]      out_pixel_y,
  output logic                              out_covered,
  output logic [COLOR_BITS-1:0]             out_pixel_color,
  output logic                              out_last
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;

  logic                          s1_valid_r;
  logic signed [PW-1:0]          prod_r [9];
  logic signed [PW-1:0]          prod_nxt [9];
  logic [COORD_BITS-1:0]         s1_px_r, s1_py_r;
  logic                          s1_last_r;
  logic                          out_valid_r;
  logic [COORD_BITS-1:0]         out_px_r, out_py_r;
  logic                          out_cov_r;
  logic [COLOR_BITS-1:0]         out_color_r;
  logic                          out_last_r;
  logic                          out_take;
  logic                          s1_take;
  logic                          cov;

  // Move a stage whenever the one after it can take the transaction
  assign out_take = !out_valid_r || !out_stall;
  assign s1_take  = !s1_valid_r || out_take;
  assign q_pop    = q_valid && s1_take;

  // Three products per edge: (ay+py)(ax-px) + (ay+by)(bx-ax) + (by+py)(px-bx)
  always_comb begin
    logic signed [DW-1:0] ax, ay, bx, by, px, py;
    for (int k = 0; k < 3; k++) begin
      ax = DW'(signed'(cand_vert[2*k]));
      ay = DW'(signed'(cand_vert[2*k+1]));
      bx = DW'(signed'(cand_vert[(2*k+2)%6]));
      by = DW'(signed'(cand_vert[(2*k+3)%6]));
      px = DW'(signed'(cand_px));
      py = DW'(signed'(cand_py));
      prod_nxt[3*k]   = (ay + py) * (ax - px);
      prod_nxt[3*k+1] = (ay + by) * (bx - ax);
      prod_nxt[3*k+2] = (by + py) * (px - bx);
    end
  end

  // Sum each edge and require all three nonnegative
  always_comb begin
    logic signed [SW-1:0] esum;
    cov = 1'b1;
    for (int k = 0; k < 3; k++) begin
      esum = SW'(prod_r[3*k]) + SW'(prod_r[3*k+1]) + SW'(prod_r[3*k+2]);
      if (esum[SW-1]) begin
        cov = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid_r <= q_valid;
      end
      if (out_take) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Hold the product stage while the output is stalled
  always_ff @(posedge clk) begin
    if (s1_take && q_valid) begin
      prod_r    <= prod_nxt;
      s1_px_r   <= cand_px;
      s1_py_r   <= cand_py;
      s1_last_r <= cand_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && s1_valid_r) begin
      out_px_r    <= s1_px_r;
      out_py_r    <= s1_py_r;
      out_cov_r   <= cov;
      out_color_r <= cov ? fill_color : '0;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_px_r;
  assign out_pixel_y     = out_py_r;
  assign out_covered     = out_cov_r;
  assign out_pixel_color = out_color_r;
  assign out_last        = out_last_r;

endmodule

// File: hdl/triangle_bbox_rasterizer.sv
// Top level of the triangle bounding-box rasterizer.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   in_      | in_valid / in_stall   | func, vert1..3 x/y
//   out_     | out_valid / out_stall | pixel_x, pixel_y, covered, color, last
//   config   | psel/penable/pready   | fill_color at byte address 0
//
// One load or step transaction is taken per cycle while in_stall is low; a step's
// pixel passes through the queue and the product stage into the output register.
// The front end stalls only when the four-entry candidate queue is full.
// Synchronous reset leaves the block idle; steps are dropped until a load.
// The coverage pipeline holds under out_stall without losing a pixel.
module triangle_bbox_rasterizer import trbr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic signed [COORD_BITS-1:0]      in_vert1_x,
  input  logic signed [COORD_BITS-1:0]      in_vert1_y,
  input  logic signed [COORD_BITS-1:0]      in_vert2_x,
  input  logic signed [COORD_BITS-1:0]      in_vert2_y,
  input  logic signed [COORD_BITS-1:0]      in_vert3_x,
  input  logic signed [COORD_BITS-1:0]      in_vert3_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [COORD_BITS-1:0]      out_pixel_x,
  output logic signed [COORD_BITS-1:0]      out_pixel_y,
  output logic                              out_covered,
  output logic [COLOR_BITS-1:0]             out_pixel_color,
  output logic                              out_last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [CFG_ADDR_BITS-1:0]          paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int ENTRY_W = 8 * COORD_BITS + 1;

  logic                          fill_color_r;
  logic [COLOR_BITS-1:0]         fill_color_q_r;
  logic                          cfg_wr;
  logic                          q_full;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_valid;
  logic [ENTRY_W-1:0]            q_wdata;
  logic [ENTRY_W-1:0]            q_rdata;
  logic [COORD_BITS-1:0]         f_px, f_py;
  logic                          f_last;
  logic [5:0][COORD_BITS-1:0]    f_vert;
  logic [COORD_BITS-1:0]         b_px, b_py;
  logic                          b_last;
  logic [5:0][COORD_BITS-1:0]    b_vert;

  // Register file: fill color only
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FILL_COLOR);
  assign prdata = (paddr[2] == REG_FILL_COLOR) ? fill_color_q_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_color_r   <= 1'b0;
      fill_color_q_r <= '0;
    end else if (cfg_wr) begin
      fill_color_r   <= 1'b1;
      fill_color_q_r <= pwdata;
    end
  end

  trbr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_func    (in_func),
    .in_vert1_x (in_vert1_x),
    .in_vert1_y (in_vert1_y),
    .in_vert2_x (in_vert2_x),
    .in_vert2_y (in_vert2_y),
    .in_vert3_x (in_vert3_x),
    .in_vert3_y (in_vert3_y),
    .q_full     (q_full),
    .cand_push  (q_push),
    .cand_px    (f_px),
    .cand_py    (f_py),
    .cand_last  (f_last),
    .cand_vert  (f_vert)
  );

  // Pack and unpack one queued candidate
  assign q_wdata = {f_last, f_py, f_px, f_vert};
  assign {b_last, b_py, b_px, b_vert} = q_rdata;

  trbr_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rdata    (q_rdata)
  );

  trbr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .cand_px         (b_px),
    .cand_py         (b_py),
    .cand_last       (b_last),
    .cand_vert       (b_vert),
    .fill_color      (fill_color_r ? fill_color_q_r : '0),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_covered     (out_covered),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last)
  );

endmodule
